### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside of reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Checks that a condition never holds at a rising edge outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_AT(label, clk, rst_n, !(cond))

`endif

### hdl/ppc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

	localparam int MAX_PILES_DEF = 26;
	localparam int SYM_W         = 8;
	localparam int TOTAL_W       = 5;

	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} ppc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // A request is accepted this cycle.
		logic capture;  // The request ends a sequence; latch its result.
	} ppc_cmd_t;

endpackage

`default_nettype wire

### hdl/ppc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ppc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           last,
	input  wire logic           out_ready,
	output logic                in_ready,
	output logic                out_valid,
	output ppc_pkg::ppc_cmd_t   cmd
);
	import ppc_pkg::*;

	ppc_state_t state_q;
	ppc_state_t state_next;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next  = state_q;
		in_ready    = 1'b1;
		out_valid   = 1'b0;
		unique case (state_q)
			ST_EMPTY: begin
				in_ready  = 1'b1;
				out_valid = 1'b0;
			end
			ST_FULL: begin
				// A new request may enter in the cycle the held result leaves.
				in_ready  = out_ready;
				out_valid = 1'b1;
			end
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
		accept      = in_valid && in_ready;
		cmd.load    = accept;
		cmd.capture = accept && last;
		if (cmd.capture) begin
			state_next = ST_FULL;
		end else if (out_valid && out_ready) begin
			state_next = ST_EMPTY;
		end
	end

endmodule

`default_nettype wire

### hdl/ppc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ppc_datapath #(
	parameter int MAX_PILES = ppc_pkg::MAX_PILES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ppc_pkg::ppc_cmd_t            cmd,
	input  wire logic [ppc_pkg::SYM_W-1:0]    symbol,
	input  wire logic                         first,
	output logic      [ppc_pkg::TOTAL_W-1:0]  pile_total,
	output logic                              overflowed
);
	import ppc_pkg::*;

	localparam int CW = $clog2(MAX_PILES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PILES);

	logic [SYM_W-1:0] tops_q [MAX_PILES];
	logic [CW-1:0]    count_q;
	logic             ovf_q;
	logic [TOTAL_W-1:0] total_q;
	logic             result_ovf_q;

	logic [CW-1:0]    eff_count;
	logic             eff_ovf;
	logic [MAX_PILES-1:0] hit;
	logic [MAX_PILES-1:0] wr;
	logic             any_hit;
	logic             full;
	logic [CW-1:0]    count_next;
	logic             ovf_next;

	// A first symbol works on an empty bank with the flag cleared.
	assign eff_count = first ? '0 : count_q;
	assign eff_ovf   = first ? 1'b0 : ovf_q;
	assign full      = (eff_count == MAX_CNT);

	// The live tops are sorted, so the hits form one run at the high end and
	// the lowest hit is the one whose lower neighbor misses.
	for (genvar k = 0; k < MAX_PILES; k++) begin : g_cmp
		localparam logic [CW-1:0] K = CW'(k);
		assign hit[k] = (K < eff_count) && (symbol <= tops_q[k]);
		if (k == 0) begin : g_lo
			assign wr[k] = hit[k] || (!any_hit && (eff_count == K));
		end else begin : g_hi
			assign wr[k] = (hit[k] && !hit[k-1]) || (!any_hit && (eff_count == K));
		end
	end

	assign any_hit    = |hit;
	assign count_next = (!any_hit && !full) ? eff_count + CW'(1) : eff_count;
	assign ovf_next   = eff_ovf || (!any_hit && full);

	assign pile_total = total_q;
	assign overflowed = result_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			count_q <= count_next;
			ovf_q   <= ovf_next;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PILES; i++) begin
			if (cmd.load && wr[i]) begin
				tops_q[i] <= symbol;
			end
		end
		if (cmd.capture) begin
			total_q      <= TOTAL_W'(count_next);
			result_ovf_q <= ovf_next;
		end
	end

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > MAX_CNT)
	`ASSERT_AT(a_ovf_only_full, clk, arst_n, ovf_q |-> (count_q == MAX_CNT))
	`ASSERT_AT(a_first_one_pile, clk, arst_n,
		(cmd.load && first) |=> (count_q == CW'(1) && !ovf_q))

endmodule

`default_nettype wire

### hdl/patience_pile_counter.sv
// Latency: a result is valid in the cycle after the request marked last is accepted.
// Throughput: one symbol per cycle; the compare against all pile tops is one level.
// A held result blocks new requests only while the output is stalled.
// Reset (arst_n low, asynchronous) empties the bank, clears the flag and drops any held result.
// Pile top registers are not reset; only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module patience_pile_counter #(
	parameter int MAX_PILES = ppc_pkg::MAX_PILES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [ppc_pkg::SYM_W-1:0]    symbol,
	input  wire logic                         first,
	input  wire logic                         last,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [ppc_pkg::TOTAL_W-1:0]  pile_total,
	output logic                              overflowed
);
	import ppc_pkg::*;

	// The controller tracks whether a result waits at the output and turns
	// the handshakes into load and capture commands for the datapath.
	ppc_cmd_t cmd;

	ppc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// The datapath holds the sorted bank of pile tops, the pile count and the
	// sticky overflow flag. Each accepted symbol either replaces the smallest
	// top that is not below it, opens a pile at the end of the bank, or sets
	// the flag when the bank is already full.
	ppc_datapath #(
		.MAX_PILES (MAX_PILES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.symbol     (symbol),
		.first      (first),
		.pile_total (pile_total),
		.overflowed (overflowed)
	);

endmodule

`default_nettype wire
